### hdl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Types, codes and decode functions shared by the line splitter modules.
// ----------------------------------------------------------------------------
package bts_pkg;

  // most results one byte can cause, and a count wide enough to hold it
  localparam int MaxRes = 5;
  localparam int CntW   = $clog2(MaxRes + 1);

  // byte values the decoder looks for
  localparam logic [7:0] BomFe      = 8'hFE;
  localparam logic [7:0] BomFf      = 8'hFF;
  localparam logic [7:0] BomEf      = 8'hEF;
  localparam logic [7:0] BomBb      = 8'hBB;
  localparam logic [7:0] BomBf      = 8'hBF;
  localparam logic [7:0] NonAscii   = 8'hFF;
  localparam logic [7:0] Utf8LeadLo = 8'd192;
  localparam logic [7:0] Utf8LeadHi = 8'd253;
  localparam logic [7:0] ChLf       = 8'h0A;
  localparam logic [7:0] ChCr       = 8'h0D;

  // utf-8 lead byte size thresholds
  localparam logic [7:0] Lead2Max = 8'd223;
  localparam logic [7:0] Lead3Max = 8'd239;
  localparam logic [7:0] Lead4Max = 8'd247;
  localparam logic [7:0] Lead5Max = 8'd251;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_EOL  = 2'd1,
    KIND_EOF  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_ONE  = 2'd1,
    PH_EFBB = 2'd2,
    PH_RUN  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_BE    = 2'd1,
    MODE_LE    = 2'd2,
    MODE_UTF8  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_CR   = 2'd1,
    PEND_LF   = 2'd2
  } pend_t;

  // decoder state
  typedef struct packed {
    phase_t     phase;
    logic [7:0] held0;
    logic [7:0] held1;
    mode_t      mode;
    logic [7:0] half_byte;
    logic       half_vld;
    logic [2:0] skip;
    pend_t      pend;
    logic       line_open;
  } st_t;

  localparam st_t StReset = '{
    phase:     PH_WAIT,
    held0:     8'h00,
    held1:     8'h00,
    mode:      MODE_PLAIN,
    half_byte: 8'h00,
    half_vld:  1'b0,
    skip:      3'd0,
    pend:      PEND_NONE,
    line_open: 1'b0
  };

  // one result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] val;
  } res_t;

  // a result that may or may not be produced
  typedef struct packed {
    logic vld;
    res_t res;
  } cand_t;

  localparam cand_t CandNone = '{vld: 1'b0, res: '{kind: KIND_CHAR, val: 8'h00}};

  // all results of one request, handed from decoder to output buffer
  typedef struct packed {
    logic [CntW-1:0]          cnt;
    res_t [MaxRes-1:0]        ent;
  } burst_t;

  typedef struct packed {
    st_t   st;
    cand_t res;
  } step_t;

  // continuation bytes that follow a utf-8 lead byte
  function automatic logic [2:0] utf8_extra(input logic [7:0] lead);
    logic [2:0] n;
    if (lead <= Lead2Max)      n = 3'd1;
    else if (lead <= Lead3Max) n = 3'd2;
    else if (lead <= Lead4Max) n = 3'd3;
    else if (lead <= Lead5Max) n = 3'd4;
    else                       n = 3'd5;
    return n;
  endfunction

  // line end pairing and result for one decoded unit
  function automatic step_t take_unit(input st_t st, input logic [7:0] u);
    step_t r;
    pend_t pend;
    logic  swallow;
    r.st     = st;
    r.res    = CandNone;
    pend     = st.pend;
    r.st.pend = PEND_NONE;
    swallow  = (pend == PEND_CR && u == ChLf) || (pend == PEND_LF && u == ChCr);
    if (!swallow) begin
      if (u == ChCr || u == ChLf) begin
        r.res.vld      = 1'b1;
        r.res.res.kind = KIND_EOL;
        r.res.res.val  = 8'h00;
        r.st.pend      = (u == ChCr) ? PEND_CR : PEND_LF;
        r.st.line_open = 1'b0;
      end else begin
        r.res.vld      = 1'b1;
        r.res.res.kind = KIND_CHAR;
        r.res.res.val  = u;
        r.st.line_open = 1'b1;
      end
    end
    return r;
  endfunction

  // one raw byte through the selected encoding
  function automatic step_t decode_byte(input st_t st, input logic [7:0] b);
    step_t      r;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [2:0] sk;
    r   = '{st: st, res: CandNone};
    hi  = 8'h00;
    lo  = 8'h00;
    sk  = 3'd0;
    unique case (st.mode)
      MODE_PLAIN: begin
        r = take_unit(st, b);
      end
      MODE_BE, MODE_LE: begin
        if (!st.half_vld) begin
          r.st.half_byte = b;
          r.st.half_vld  = 1'b1;
        end else begin
          hi = (st.mode == MODE_BE) ? st.half_byte : b;
          lo = (st.mode == MODE_BE) ? b : st.half_byte;
          r.st.half_vld = 1'b0;
          r = take_unit(r.st, (hi == 8'h00) ? lo : NonAscii);
        end
      end
      MODE_UTF8: begin
        if (st.skip != 3'd0) begin
          sk = st.skip - 3'd1;
          r.st.skip = sk;
          if (sk == 3'd0) r = take_unit(r.st, NonAscii);
        end else if (b >= Utf8LeadLo && b <= Utf8LeadHi) begin
          r.st.skip = utf8_extra(b);
        end else begin
          r = take_unit(st, b);
        end
      end
    endcase
    return r;
  endfunction

endpackage

### hdl/bts_in_if.sv
// ----------------------------------------------------------------------------
// bts_in_if
// Raw byte channel into the line splitter.
// ----------------------------------------------------------------------------
interface bts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

### hdl/bts_out_if.sv
// ----------------------------------------------------------------------------
// bts_out_if
// Result channel out of the line splitter.
// ----------------------------------------------------------------------------
interface bts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] char_value;
  logic       run_last;

  modport source (output valid, output item_kind, output char_value, output run_last,
                  input ready);
  modport sink   (input valid, input item_kind, input char_value, input run_last,
                  output ready);
endinterface

### hdl/bts_decode.sv
// ----------------------------------------------------------------------------
// bts_decode
// Mark detection, unit decoding and line end pairing for one request.
// ----------------------------------------------------------------------------
module bts_decode (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            final_byte,
  output bts_pkg::burst_t burst
);
  import bts_pkg::*;

  st_t             st_r;
  st_t             st_nxt;
  st_t             st_dec;
  cand_t [MaxRes-1:0] cand;

  // decode chain: detection phase, then up to three units, then file end
  always_comb begin : p_chain
    st_t   s;
    step_t t;
    s       = st_r;
    t       = '{st: st_r, res: CandNone};
    cand    = {MaxRes{CandNone}};
    unique case (st_r.phase)
      PH_WAIT: begin
        if (final_byte) begin
          s.mode  = MODE_PLAIN;
          s.phase = PH_RUN;
          t = decode_byte(s, data_byte);
          s = t.st;
          cand[0] = t.res;
        end else begin
          s.held0 = data_byte;
          s.phase = PH_ONE;
        end
      end
      PH_ONE: begin
        if (st_r.held0 == BomFe && data_byte == BomFf) begin
          s.mode  = MODE_BE;
          s.phase = PH_RUN;
        end else if (st_r.held0 == BomFf && data_byte == BomFe) begin
          s.mode  = MODE_LE;
          s.phase = PH_RUN;
        end else if (st_r.held0 == BomEf && data_byte == BomBb && !final_byte) begin
          s.held1 = data_byte;
          s.phase = PH_EFBB;
        end else begin
          s.mode  = MODE_PLAIN;
          s.phase = PH_RUN;
          t = decode_byte(s, st_r.held0);
          s = t.st;
          cand[0] = t.res;
          t = decode_byte(s, data_byte);
          s = t.st;
          cand[1] = t.res;
        end
      end
      PH_EFBB: begin
        s.phase = PH_RUN;
        if (data_byte == BomBf) begin
          s.mode = MODE_UTF8;
        end else begin
          s.mode = MODE_PLAIN;
          t = decode_byte(s, st_r.held0);
          s = t.st;
          cand[0] = t.res;
          t = decode_byte(s, st_r.held1);
          s = t.st;
          cand[1] = t.res;
          t = decode_byte(s, data_byte);
          s = t.st;
          cand[2] = t.res;
        end
      end
      PH_RUN: begin
        t = decode_byte(s, data_byte);
        s = t.st;
        cand[0] = t.res;
      end
    endcase
    // file end closes an open line, then marks end of file
    if (final_byte && s.line_open) begin
      cand[3] = '{vld: 1'b1, res: '{kind: KIND_EOL, val: 8'h00}};
    end
    if (final_byte) begin
      cand[4] = '{vld: 1'b1, res: '{kind: KIND_EOF, val: 8'h00}};
    end
    st_dec = s;
  end

  // next state: file end returns everything to reset
  always_comb begin
    st_nxt = st_r;
    if (accept) begin
      st_nxt = final_byte ? StReset : st_dec;
    end
  end

  // pack the produced results in order
  always_comb begin : p_pack
    logic [CntW-1:0] n;
    n         = '0;
    burst.ent = '0;
    for (int i = 0; i < MaxRes; i++) begin
      if (cand[i].vld) begin
        burst.ent[n] = cand[i].res;
        n = n + CntW'(1);
      end
    end
    burst.cnt = n;
  end

  // decoder state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StReset;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

### hdl/bts_burst.sv
// ----------------------------------------------------------------------------
// bts_burst
// Result register that holds the burst of one request and drains it in order.
// ----------------------------------------------------------------------------
module bts_burst (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  bts_pkg::burst_t burst,
  output logic            ready,
  bts_out_if.source       out_bus
);
  import bts_pkg::*;

  res_t [MaxRes-1:0] ent_r;
  res_t [MaxRes-1:0] ent_nxt;
  logic [CntW-1:0]   left_r;
  logic [CntW-1:0]   left_nxt;
  logic              pop;

  assign pop = out_bus.valid && out_bus.ready;

  // a new burst may enter once the last result of the current one leaves
  assign ready = (left_r == CntW'(0)) || (left_r == CntW'(1) && out_bus.ready);

  // remaining count and shift toward the head
  always_comb begin
    left_nxt = left_r;
    ent_nxt  = ent_r;
    if (pop) begin
      left_nxt = left_r - CntW'(1);
      for (int i = 0; i < MaxRes - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
    end
    if (load && burst.cnt != CntW'(0)) begin
      left_nxt = burst.cnt;
      ent_nxt  = burst.ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  // head of the burst drives the channel
  assign out_bus.valid      = (left_r != CntW'(0));
  assign out_bus.item_kind  = ent_r[0].kind;
  assign out_bus.char_value = ent_r[0].val;
  assign out_bus.run_last   = (left_r == CntW'(1));

endmodule

### hdl/bom_text_line_splitter.sv
// ----------------------------------------------------------------------------
// bom_text_line_splitter
// Byte-order mark detecting decoder that splits a file into characters,
// line ends and an end of file marker.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------
//   in_bus   | in  | valid / ready | data_byte[7:0], final_byte
//   out_bus  | out | valid / ready | item_kind[1:0], char_value[7:0], run_last
//
// A request is decoded in the cycle it is taken and its results land in the
// burst register; a byte that yields several results is shown on out_bus one
// result at a time and ready stays low until its last result is taken, so one
// byte per cycle runs whenever each byte yields at most one result and out_bus
// does not stall. Reset is synchronous; no clearing pass follows.
// A stalled out_bus holds its burst; ready returns in the cycle the last
// result of that burst is taken.
// ----------------------------------------------------------------------------
module bom_text_line_splitter (
  input  logic      clk,
  input  logic      rst_n,
  bts_in_if.sink    in_bus,
  bts_out_if.source out_bus
);
  import bts_pkg::*;

  logic   rdy;
  logic   accept;
  burst_t burst;

  assign in_bus.ready = rdy;
  assign accept       = in_bus.valid && rdy;

  // decode of the accepted request
  bts_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_bus.data_byte),
    .final_byte (in_bus.final_byte),
    .burst      (burst)
  );

  // result register and drain
  bts_burst u_burst (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept),
    .burst   (burst),
    .ready   (rdy),
    .out_bus (out_bus)
  );

endmodule

### hdl/bts_checker.sv
// ----------------------------------------------------------------------------
// bts_checker
// Port level checks on the line splitter, bound to the top level.
// ----------------------------------------------------------------------------
module bts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] item_kind,
  input logic [7:0] char_value,
  input logic       run_last
);
  import bts_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(item_kind) &&
    $stable(char_value) && $stable(run_last))
    else $error("stalled result changed");

  // a burst drains without gaps
  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !run_last |=> out_valid)
    else $error("gap inside a result burst");

  // no new request while a burst has more than its last result left
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !run_last |-> !in_ready)
    else $error("request taken while burst pending");

  // end of file always closes the burst of its request
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && item_kind == KIND_EOF |-> run_last)
    else $error("end of file not last in burst");

  // line and file end carry no character
  a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (item_kind == KIND_EOL || item_kind == KIND_EOF) |-> char_value == 8'h00)
    else $error("nonzero value on line or file end");

endmodule

bind bom_text_line_splitter bts_checker u_bts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .item_kind  (out_bus.item_kind),
  .char_value (out_bus.char_value),
  .run_last   (out_bus.run_last)
);

### dv/tb_bom_text_line_splitter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bom_text_line_splitter
// Sends whole files byte by byte into the splitter: short directed files for
// the mark cases, then random files with random or broken marks under four
// idle and stall mixes. A predictor tracks the decoder state and every result
// is checked in order against the expected characters and line ends.
// ----------------------------------------------------------------------------
module tb_bom_text_line_splitter;
  import bts_pkg::*;

  // one expected result
  typedef struct {
    kind_t      kind;
    logic [7:0] val;
    logic       run_last;
  } text_item_t;

  logic clk = 1'b0;
  logic rst_n;

  bts_in_if  in_bus ();
  bts_out_if out_bus ();

  bom_text_line_splitter i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // predictor state and result stores
  st_t        line_state;
  text_item_t byte_results[$];
  text_item_t expected_items[$];
  logic [7:0] file_bytes[$];

  int gap_pct    = 0;
  int stall_pct  = 0;
  int err_count  = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int items_seen = 0;
  int eof_seen   = 0;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [2:0] utf8_tail_len(input logic [7:0] lead);
    if (lead < 8'd224) return 3'd1;
    if (lead < 8'd240) return 3'd2;
    if (lead < 8'd248) return 3'd3;
    if (lead < 8'd252) return 3'd4;
    return 3'd5;
  endfunction

  function automatic void add_result(input kind_t kind, input logic [7:0] val);
    byte_results.push_back('{kind, val, 1'b0});
  endfunction

  // line end pairing for one decoded unit
  function automatic void take_text_unit(input logic [7:0] u);
    pend_t prev;
    prev = line_state.pend;
    line_state.pend = PEND_NONE;
    if ((prev == PEND_CR && u == ChLf) || (prev == PEND_LF && u == ChCr)) return;
    if (u == ChCr || u == ChLf) begin
      add_result(KIND_EOL, 8'h00);
      line_state.pend = (u == ChCr) ? PEND_CR : PEND_LF;
      line_state.line_open = 1'b0;
    end else begin
      add_result(KIND_CHAR, u);
      line_state.line_open = 1'b1;
    end
  endfunction

  // one raw byte through the chosen encoding
  function automatic void decode_raw(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    case (line_state.mode)
      MODE_PLAIN: take_text_unit(b);
      MODE_BE, MODE_LE: begin
        if (!line_state.half_vld) begin
          line_state.half_byte = b;
          line_state.half_vld  = 1'b1;
        end else begin
          hi = (line_state.mode == MODE_BE) ? line_state.half_byte : b;
          lo = (line_state.mode == MODE_BE) ? b : line_state.half_byte;
          line_state.half_vld = 1'b0;
          take_text_unit((hi == 8'h00) ? lo : NonAscii);
        end
      end
      default: begin
        if (line_state.skip != 3'd0) begin
          line_state.skip = line_state.skip - 3'd1;
          if (line_state.skip == 3'd0) take_text_unit(NonAscii);
        end else if (b >= Utf8LeadLo && b <= Utf8LeadHi) begin
          line_state.skip = utf8_tail_len(b);
        end else begin
          take_text_unit(b);
        end
      end
    endcase
  endfunction

  // expected results of one accepted request
  function automatic void predict_request(input logic [7:0] b, input logic fin);
    byte_results.delete();
    case (line_state.phase)
      PH_WAIT: begin
        if (fin) begin
          line_state.mode  = MODE_PLAIN;
          line_state.phase = PH_RUN;
          decode_raw(b);
        end else begin
          line_state.held0 = b;
          line_state.phase = PH_ONE;
        end
      end
      PH_ONE: begin
        line_state.phase = PH_RUN;
        if (line_state.held0 == BomFe && b == BomFf) begin
          line_state.mode = MODE_BE;
        end else if (line_state.held0 == BomFf && b == BomFe) begin
          line_state.mode = MODE_LE;
        end else if (line_state.held0 == BomEf && b == BomBb && !fin) begin
          line_state.held1 = b;
          line_state.phase = PH_EFBB;
        end else begin
          line_state.mode = MODE_PLAIN;
          decode_raw(line_state.held0);
          decode_raw(b);
        end
      end
      PH_EFBB: begin
        line_state.phase = PH_RUN;
        if (b == BomBf) begin
          line_state.mode = MODE_UTF8;
        end else begin
          line_state.mode = MODE_PLAIN;
          decode_raw(line_state.held0);
          decode_raw(line_state.held1);
          decode_raw(b);
        end
      end
      default: decode_raw(b);
    endcase
    // end of file closes a non-empty line and starts over
    if (fin) begin
      if (line_state.line_open) add_result(KIND_EOL, 8'h00);
      add_result(KIND_EOF, 8'h00);
      line_state = StReset;
    end
    if (byte_results.size() > 0) byte_results[$].run_last = 1'b1;
    foreach (byte_results[i]) expected_items.push_back(byte_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // driving and checking
  // ---------------------------------------------------------------------------

  function automatic void report_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    // each cycle idles with the chosen chance
    while ($urandom_range(0, 99) < gap_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid      = 1'b1;
    in_bus.data_byte  = b;
    in_bus.final_byte = fin;
    do @(posedge clk); while (!in_bus.ready);
    predict_request(b, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    files_sent++;
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_bus.ready = ($urandom_range(0, 99) >= stall_pct);
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin : check_results
    text_item_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      items_seen++;
      if (out_bus.item_kind == KIND_EOF) eof_seen++;
      if (expected_items.size() == 0) begin
        report_error($sformatf("unexpected result kind=%0d val=%02h last=%0b",
                               out_bus.item_kind, out_bus.char_value, out_bus.run_last));
      end else begin
        want = expected_items.pop_front();
        if (out_bus.item_kind !== want.kind || out_bus.char_value !== want.val ||
            out_bus.run_last !== want.run_last) begin
          report_error($sformatf("exp kind=%0d val=%02h last=%0b got kind=%0d val=%02h last=%0b",
                                 want.kind, want.val, want.run_last, out_bus.item_kind,
                                 out_bus.char_value, out_bus.run_last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // one byte file, mark only file, EF BB file replayed as plain
  task automatic test_short_files();
    file_bytes = '{8'h0A};
    send_file();
    file_bytes = '{BomFe, BomFf};
    send_file();
    file_bytes = '{BomEf, BomBb};
    send_file();
  endtask

  // little endian units, CR LF pair and a dropped half unit
  task automatic test_utf16_le();
    file_bytes = '{BomFf, BomFe, 8'h41, 8'h00, ChCr, 8'h00, ChLf, 8'h00, 8'h43};
    send_file();
  endtask

  // two byte sequence, paired line end, truncated lead at end of file
  task automatic test_utf8_mark();
    file_bytes = '{BomEf, BomBb, BomBf, 8'hC3, 8'hA9, ChCr, ChLf, 8'hE2};
    send_file();
  endtask

  // EF BB then a mismatch replays three bytes: five results on the last byte
  task automatic test_mark_replay();
    file_bytes = '{BomEf, BomBb, 8'h41};
    send_file();
  endtask

  // random file with a random, broken or absent mark
  task automatic build_random_file();
    int         sel;
    int         n_units;
    int         tail;
    logic [7:0] u;
    logic [7:0] hi;
    mode_t      enc;
    file_bytes.delete();
    enc = MODE_PLAIN;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: begin
        file_bytes = '{BomFe, BomFf};
        enc = MODE_BE;
      end
      2, 3: begin
        file_bytes = '{BomFf, BomFe};
        enc = MODE_LE;
      end
      4, 5: begin
        file_bytes = '{BomEf, BomBb, BomBf};
        enc = MODE_UTF8;
      end
      6: begin
        // broken mark falls back to plain
        case ($urandom_range(0, 2))
          0: file_bytes = '{BomFe, 8'($urandom_range(0, 8'hFE))};
          1: file_bytes = '{BomEf, 8'($urandom_range(0, 8'hBA))};
          default: file_bytes = '{BomEf, BomBb, 8'($urandom_range(0, 8'hBE))};
        endcase
      end
      default: ;
    endcase
    n_units = $urandom_range(0, 10);
    if (file_bytes.size() == 0 && n_units == 0) n_units = 1;
    repeat (n_units) begin
      case ($urandom_range(0, 9))
        0: u = ChCr;
        1: u = ChLf;
        2, 3, 4, 5: u = 8'($urandom_range(8'h20, 8'h7E));
        default: u = 8'($urandom_range(0, 255));
      endcase
      case (enc)
        MODE_BE, MODE_LE: begin
          hi = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
          if (enc == MODE_BE) begin
            file_bytes.push_back(hi);
            file_bytes.push_back(u);
          end else begin
            file_bytes.push_back(u);
            file_bytes.push_back(hi);
          end
        end
        MODE_UTF8: begin
          file_bytes.push_back(u);
          if (u >= Utf8LeadLo && u <= Utf8LeadHi) begin
            tail = utf8_tail_len(u);
            repeat (tail) begin
              if ($urandom_range(0, 4) == 0) file_bytes.push_back(8'($urandom_range(0, 255)));
              else file_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
          end
        end
        default: file_bytes.push_back(u);
      endcase
    end
    // sometimes leave a unit unfinished at end of file
    if ($urandom_range(0, 3) == 0) begin
      if (enc == MODE_BE || enc == MODE_LE) begin
        file_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (enc == MODE_UTF8) begin
        file_bytes.push_back(8'($urandom_range(Utf8LeadLo, Utf8LeadHi)));
      end
    end
  endtask

  task automatic test_random_files(input int gap, input int stall);
    int start;
    gap_pct   = gap;
    stall_pct = stall;
    start     = bytes_sent;
    while (bytes_sent - start < 20) begin
      build_random_file();
      send_file();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    int waited;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = 8'h00;
    in_bus.final_byte = 1'b0;
    line_state        = StReset;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_short_files();
    test_utf16_le();
    test_utf8_mark();
    test_mark_replay();
    test_random_files(0, 0);
    test_random_files(46, 0);
    test_random_files(0, 46);
    test_random_files(20, 20);

    in_bus.valid = 1'b0;
    waited = 0;
    while (expected_items.size() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_items.size() > 0) begin
      report_error($sformatf("%0d expected results never arrived", expected_items.size()));
    end

    $display("covered %0d bytes in %0d files across four idle/stall mixes", bytes_sent,
             files_sent);
    $display("checked %0d results, %0d of them end of file", items_seen, eof_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### bom_text_line_splitter.f
hdl/bts_pkg.sv
hdl/bts_in_if.sv
hdl/bts_out_if.sv
hdl/bts_decode.sv
hdl/bts_burst.sv
hdl/bom_text_line_splitter.sv
hdl/bts_checker.sv
dv/tb_bom_text_line_splitter.sv
